[rtl/core/lru_instance_activity_table_defines.svh]
// Assertion helpers for the activity table.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LRU_INSTANCE_ACTIVITY_TABLE_DEFINES_SVH
`define LRU_INSTANCE_ACTIVITY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LIAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("activity table check failed");

// Next-cycle implication, disabled during reset.
`define LIAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("activity table check failed");

`endif

[rtl/core/liat_pkg.sv]
package liat_pkg;

  // Field widths of a transaction
  localparam int unsigned GroupW    = 17;
  localparam int unsigned SourceW   = 8;
  localparam int unsigned InstW     = 16;
  localparam int unsigned KeyInstW  = 15;
  localparam int unsigned TimeW     = 63;
  localparam int unsigned CountW    = 32;
  localparam int unsigned OutcomeW  = 3;
  localparam int unsigned SlotOutW  = 4;

  // Command codes
  localparam logic CMD_NOTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Outcome codes
  localparam logic [OutcomeW-1:0] OUT_IGNORED = 3'd0;
  localparam logic [OutcomeW-1:0] OUT_HIT     = 3'd1;
  localparam logic [OutcomeW-1:0] OUT_NEW     = 3'd2;
  localparam logic [OutcomeW-1:0] OUT_EVICT   = 3'd3;
  localparam logic [OutcomeW-1:0] OUT_CLEARED = 3'd4;

  // One table entry as held in the memory
  typedef struct packed {
    logic [GroupW-1:0]   group;
    logic [SourceW-1:0]  source;
    logic [KeyInstW-1:0] inst;
    logic [CountW-1:0]   count;
    logic [TimeW-1:0]    last_seen;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input transaction, restart the scan
    logic scan;      // issue next read, evaluate previous read
    logic skip;      // finish a clear or ignored transaction
    logic write;     // update the picked entry, build the result
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;       // clear command or negative instance
    logic scan_done;  // hit found or last entry evaluated
  } dp_status_t;

endpackage

[rtl/core/liat_ctrl.sv]
module liat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  liat_pkg::dp_status_t status_i,
  output liat_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode datapath commands from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.scan     = (state_q == ST_SCAN) && !status_i.skip;
    cmd_o.skip     = (state_q == ST_SCAN) && status_i.skip;
    cmd_o.write    = (state_q == ST_WRITE);
    cmd_o.out_load = (state_q == ST_FINISH) && out_free;
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.skip) begin
            state_q <= ST_FINISH;
          end else if (status_i.scan_done) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/liat_dp.sv]
module liat_dp #(
  parameter int unsigned TableSlots = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  command_i,
  input  logic [liat_pkg::GroupW-1:0]           group_number_i,
  input  logic [liat_pkg::SourceW-1:0]          source_addr_i,
  input  logic signed [liat_pkg::InstW-1:0]     instance_num_i,
  input  logic [liat_pkg::TimeW-1:0]            now_time_i,
  input  liat_pkg::ctrl_cmd_t                   cmd_i,
  output liat_pkg::dp_status_t                  status_o,
  output logic [liat_pkg::OutcomeW-1:0]         outcome_o,
  output logic [liat_pkg::SlotOutW-1:0]         slot_index_o,
  output logic [liat_pkg::CountW-1:0]           hit_count_o
);

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CntW = $clog2(TableSlots + 1);

  // Captured transaction
  logic                            clear_q;
  logic [liat_pkg::GroupW-1:0]     grp_q;
  logic [liat_pkg::SourceW-1:0]    src_q;
  logic [liat_pkg::InstW-1:0]      inst_q;
  logic [liat_pkg::TimeW-1:0]      now_q;

  // Table storage
  liat_pkg::entry_t                mem [TableSlots];
  logic [TableSlots-1:0]           valid_q;

  // Scan read stage
  logic [CntW-1:0]                 addr_q;
  logic                            issue;
  liat_pkg::entry_t                rd_q;
  logic                            rd_vld_q;
  logic                            rd_live_q;
  logic [IdxW-1:0]                 rd_idx_q;

  // Scan trackers
  logic                            hit_q;
  logic [IdxW-1:0]                 hit_idx_q;
  logic [liat_pkg::CountW-1:0]     hit_cnt_q;
  logic                            empty_q;
  logic [IdxW-1:0]                 empty_idx_q;
  logic                            old_q;
  logic [IdxW-1:0]                 old_idx_q;
  logic [liat_pkg::TimeW-1:0]      old_time_q;

  // Result held until the output register frees up
  logic [liat_pkg::OutcomeW-1:0]   res_outcome_q;
  logic [liat_pkg::SlotOutW-1:0]   res_slot_q;
  logic [liat_pkg::CountW-1:0]     res_count_q;
  logic [liat_pkg::OutcomeW-1:0]   out_outcome_q;
  logic [liat_pkg::SlotOutW-1:0]   out_slot_q;
  logic [liat_pkg::CountW-1:0]     out_count_q;

  logic                            key_match;
  logic                            eval_hit;
  logic                            eval_last;
  logic [IdxW-1:0]                 pick;
  logic [IdxW+liat_pkg::SlotOutW-1:0] pick_ext;
  logic [liat_pkg::CountW-1:0]     new_count;
  logic [liat_pkg::OutcomeW-1:0]   pick_outcome;

  // Evaluate the entry read in the previous cycle
  assign key_match = (rd_q.group == grp_q) && (rd_q.source == src_q) &&
                     (rd_q.inst == inst_q[liat_pkg::KeyInstW-1:0]);
  assign eval_hit  = rd_live_q && rd_vld_q && key_match;
  assign eval_last = rd_live_q && (rd_idx_q == IdxW'(TableSlots - 1));
  assign issue     = cmd_i.scan && (addr_q < CntW'(TableSlots));

  assign status_o.skip      = (clear_q == liat_pkg::CMD_CLEAR) || inst_q[liat_pkg::InstW-1];
  assign status_o.scan_done = eval_hit || eval_last;

  // Pick hit, then first empty, then oldest
  always_comb begin
    priority if (hit_q) begin
      pick         = hit_idx_q;
      pick_outcome = liat_pkg::OUT_HIT;
    end else if (empty_q) begin
      pick         = empty_idx_q;
      pick_outcome = liat_pkg::OUT_NEW;
    end else begin
      pick         = old_idx_q;
      pick_outcome = liat_pkg::OUT_EVICT;
    end
  end

  assign new_count = hit_q ? (hit_cnt_q + liat_pkg::CountW'(1)) : liat_pkg::CountW'(1);
  assign pick_ext  = {{liat_pkg::SlotOutW{1'b0}}, pick};

  // Capture the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      clear_q <= command_i;
      grp_q   <= group_number_i;
      src_q   <= source_addr_i;
      inst_q  <= $unsigned(instance_num_i);
      now_q   <= now_time_i;
    end
  end

  // Read and write the entry memory
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q     <= mem[addr_q[IdxW-1:0]];
      rd_vld_q <= valid_q[addr_q[IdxW-1:0]];
      rd_idx_q <= addr_q[IdxW-1:0];
    end
    if (cmd_i.write) begin
      mem[pick] <= '{group:     grp_q,
                     source:    src_q,
                     inst:      inst_q[liat_pkg::KeyInstW-1:0],
                     count:     new_count,
                     last_seen: now_q};
    end
  end

  // Valid bits: set on write, drop all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.skip && (clear_q == liat_pkg::CMD_CLEAR)) begin
      valid_q <= '0;
    end else if (cmd_i.write) begin
      valid_q[pick] <= 1'b1;
    end
  end

  // Advance the scan and track hit, empty and oldest entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_live_q <= 1'b0;
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
      old_q     <= 1'b0;
    end else if (cmd_i.load) begin
      addr_q    <= '0;
      rd_live_q <= 1'b0;
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
      old_q     <= 1'b0;
    end else begin
      rd_live_q <= issue;
      if (issue) begin
        addr_q <= addr_q + CntW'(1);
      end
      if (cmd_i.scan && rd_live_q) begin
        if (rd_vld_q) begin
          if (key_match) begin
            hit_q <= 1'b1;
          end else if (!old_q || (rd_q.last_seen < old_time_q)) begin
            old_q <= 1'b1;
          end
        end else if (!empty_q) begin
          empty_q <= 1'b1;
        end
      end
    end
  end

  // Tracker payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && rd_live_q) begin
      if (rd_vld_q) begin
        if (key_match) begin
          hit_idx_q <= rd_idx_q;
          hit_cnt_q <= rd_q.count;
        end else if (!old_q || (rd_q.last_seen < old_time_q)) begin
          old_idx_q  <= rd_idx_q;
          old_time_q <= rd_q.last_seen;
        end
      end else if (!empty_q) begin
        empty_idx_q <= rd_idx_q;
      end
    end
  end

  // Build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.skip) begin
      res_outcome_q <= (clear_q == liat_pkg::CMD_CLEAR) ? liat_pkg::OUT_CLEARED
                                                        : liat_pkg::OUT_IGNORED;
      res_slot_q    <= '0;
      res_count_q   <= '0;
    end else if (cmd_i.write) begin
      res_outcome_q <= pick_outcome;
      res_slot_q    <= pick_ext[liat_pkg::SlotOutW-1:0];
      res_count_q   <= new_count;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_outcome_q <= res_outcome_q;
      out_slot_q    <= res_slot_q;
      out_count_q   <= res_count_q;
    end
  end

  assign outcome_o    = out_outcome_q;
  assign slot_index_o = out_slot_q;
  assign hit_count_o  = out_count_q;

endmodule

[rtl/core/lru_instance_activity_table.sv]
// A note transaction is accepted in idle, scans the entries one per cycle until a hit or
// the last entry (1 to TABLE_SLOTS entries scanned), writes the picked entry and then
// waits for the output register to free. Clear and ignored transactions skip the scan and
// the write. One transaction at a time: the next is accepted once the result is registered
// and the controller is back in idle. The scan rate is set by the single read port of the entry memory.
// Reset (async, active low) clears all valid bits, so the table starts empty.
`include "lru_instance_activity_table_defines.svh"

module lru_instance_activity_table #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic [liat_pkg::GroupW-1:0]           group_number_i,
  input  logic [liat_pkg::SourceW-1:0]          source_addr_i,
  input  logic signed [liat_pkg::InstW-1:0]     instance_num_i,
  input  logic [liat_pkg::TimeW-1:0]            now_time_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [liat_pkg::OutcomeW-1:0]         outcome_o,
  output logic [liat_pkg::SlotOutW-1:0]         slot_index_o,
  output logic [liat_pkg::CountW-1:0]           hit_count_o
);

  liat_pkg::ctrl_cmd_t  cmd;
  liat_pkg::dp_status_t status;
  logic                 res_skip;
  logic                 res_fresh;

  liat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  liat_dp #(
    .TableSlots (TABLE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (command_i),
    .group_number_i (group_number_i),
    .source_addr_i  (source_addr_i),
    .instance_num_i (instance_num_i),
    .now_time_i     (now_time_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .outcome_o      (outcome_o),
    .slot_index_o   (slot_index_o),
    .hit_count_o    (hit_count_o)
  );

  // Classify the result on the output
  assign res_skip  = out_valid_o && ((outcome_o == liat_pkg::OUT_CLEARED) ||
                                     (outcome_o == liat_pkg::OUT_IGNORED));
  assign res_fresh = out_valid_o && ((outcome_o == liat_pkg::OUT_NEW) ||
                                     (outcome_o == liat_pkg::OUT_EVICT));

  // Busy right after a transaction is taken
  `LIAT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // Clear and ignored results carry no slot and no count
  `LIAT_ASSERT_IMPL(a_skip_result_zero, res_skip, (slot_index_o == '0) && (hit_count_o == '0))

  // A freshly keyed entry always reports a count of one
  `LIAT_ASSERT_IMPL(a_fresh_count_one, res_fresh, hit_count_o == liat_pkg::CountW'(1))

endmodule
